// ===== hdl/talc_pkg.sv =====
// Shared constants, register codes and controller/datapath handshake types.
`default_nettype none
package talc_pkg;

    localparam int MAX_TILE_DEF       = 32;
    localparam int MAX_COLUMNS_DEF    = 1024;
    localparam int HUD_BASE_LINES_DEF = 224;

    localparam int LINE_LIMIT  = 1024;
    localparam int VISIBLE_MIN = 6375;
    localparam int HEIGHT_BASE = 205;
    localparam int HEIGHT_DIV  = 25500000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUD_UNITS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUD_VOXELIZED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN   = 3'd5;

    typedef struct packed {
        logic clear;
        logic accept;
        logic update;
        logic div_step;
        logic luma;
        logic hgt_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic restart;
        logic clear_done;
        logic close;
        logic div_done;
        logic hgt_done;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

// ===== hdl/talc_ctrl.sv =====
// Sequencing state machine: clear pass, accumulate, divide, luma, height, output.
`default_nettype none
module talc_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  talc_pkg::sts_t      sts,
    output talc_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_LUMA  = 3'd4;
    localparam logic [2:0] S_HGT   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.update = 1'b1;
                state_next = sts.close ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_LUMA;
            end
            S_LUMA:
            begin
                cmd.luma   = 1'b1;
                state_next = S_HGT;
            end
            S_HGT:
            begin
                cmd.hgt_step = 1'b1;
                if (sts.hgt_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        if (sts.restart)
            state_next = S_CLEAR;
    end

endmodule
`default_nettype wire

// ===== hdl/talc_dp.sv =====
// Datapath: config registers, raster position, column sum memory, dividers, output register.
`default_nettype none
module talc_dp #(
    parameter int MAX_TILE       = talc_pkg::MAX_TILE_DEF,
    parameter int MAX_COLUMNS    = talc_pkg::MAX_COLUMNS_DEF,
    parameter int HUD_BASE_LINES = talc_pkg::HUD_BASE_LINES_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    input  wire [talc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [talc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire [talc_pkg::IN_DATA_W-1:0]      pix_data,
    input  talc_pkg::cmd_t                     cmd,
    output talc_pkg::sts_t                     sts,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [talc_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                               out_user,
    output logic                               out_last
);

    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int WW    = $clog2(MAX_COLUMNS + 1);
    localparam int TW    = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
    localparam int SW    = $clog2(MAX_TILE + 1);
    localparam int HPW   = 19;
    localparam int MEMW  = 65;
    localparam int SUMW  = 18;
    localparam int CNTW  = 11;

    // reciprocal of the HUD base: exact floor for any product below 2**HPW
    localparam int     HUD_K     = HPW + $clog2(HUD_BASE_LINES + 1);
    localparam int     HMW       = HUD_K + 1;
    localparam longint HUD_RECIP = ((longint'(1) << HUD_K) + HUD_BASE_LINES - 1) /
                                   HUD_BASE_LINES;

    // 4096/HEIGHT_DIV reduces to 128/HGT_DEN; reciprocal exact for products below 2**28
    localparam longint      HGT_DEN   = longint'(talc_pkg::HEIGHT_DIV) / 32;
    localparam int          HGT_K     = 55;
    localparam int          HGT_SH    = HGT_K - 7;
    localparam longint      HGT_RECIP = ((longint'(1) << HGT_K) + HGT_DEN - 1) / HGT_DEN;
    localparam logic [17:0] HGT_M_LO  = 18'(HGT_RECIP % 262144);
    localparam logic [17:0] HGT_M_HI  = 18'(HGT_RECIP / 262144);

    // configuration registers
    logic [10:0] frame_width_reg;
    logic [10:0] frame_height_reg;
    logic [5:0]  tile_size_reg;
    logic [7:0]  hud_units_reg;
    logic        hud_voxelized_reg;
    logic [9:0]  height_gain_reg;
    logic        restart;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                talc_pkg::REG_FRAME_WIDTH:   restart = 1'b1;
                talc_pkg::REG_FRAME_HEIGHT:  restart = 1'b1;
                talc_pkg::REG_TILE_SIZE:     restart = 1'b1;
                talc_pkg::REG_HUD_UNITS:     restart = 1'b1;
                talc_pkg::REG_HUD_VOXELIZED: restart = 1'b1;
                talc_pkg::REG_HEIGHT_GAIN:   restart = 1'b1;
                default:                     restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= 11'd256;
            frame_height_reg  <= 11'd224;
            tile_size_reg     <= 6'd8;
            hud_units_reg     <= 8'd0;
            hud_voxelized_reg <= 1'b1;
            height_gain_reg   <= 10'd100;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                talc_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                talc_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                talc_pkg::REG_TILE_SIZE:     tile_size_reg     <= cfg_data[5:0];
                talc_pkg::REG_HUD_UNITS:     hud_units_reg     <= cfg_data[7:0];
                talc_pkg::REG_HUD_VOXELIZED: hud_voxelized_reg <= cfg_data[0];
                talc_pkg::REG_HEIGHT_GAIN:   height_gain_reg   <= cfg_data[9:0];
                default:                     ;
            endcase
        end
    end

    // clamped geometry
    logic [WW-1:0] w_eff;
    logic [10:0]   h_eff;
    logic [SW-1:0] s_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(frame_width_reg) > MAX_COLUMNS)
            w_eff = WW'(MAX_COLUMNS);
        else
            w_eff = WW'(frame_width_reg);
        if (frame_height_reg == '0)
            h_eff = 11'd1;
        else if (32'(frame_height_reg) > talc_pkg::LINE_LIMIT)
            h_eff = 11'(talc_pkg::LINE_LIMIT);
        else
            h_eff = frame_height_reg;
        if (tile_size_reg == '0)
            s_eff = SW'(1);
        else if (32'(tile_size_reg) > MAX_TILE)
            s_eff = SW'(MAX_TILE);
        else
            s_eff = SW'(tile_size_reg);
    end

    // clear sweep and HUD band division run together after reset or restart
    logic [XW-1:0]      clr_addr_reg;
    logic [4:0]         hud_cnt_reg;
    logic [HPW-1:0]     hud_p_reg;
    logic [HPW-1:0]     hud_q_reg;
    logic [HPW+HMW-1:0] hud_full;
    logic [HPW-1:0]     hud_prod;
    logic               clr_last;
    logic               hud_done;

    assign hud_prod = HPW'(hud_units_reg) * HPW'(h_eff);
    assign hud_full = (HPW+HMW)'(hud_p_reg) * (HPW+HMW)'(HUD_RECIP);
    assign clr_last = (clr_addr_reg == XW'(MAX_COLUMNS - 1));
    assign hud_done = (hud_cnt_reg == 5'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            hud_cnt_reg  <= '0;
        end
        else if (restart)
        begin
            clr_addr_reg <= '0;
            hud_cnt_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            if (!clr_last)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (!hud_done)
                hud_cnt_reg <= hud_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear && !hud_done)
        begin
            if (hud_cnt_reg == '0)
                hud_p_reg <= hud_prod;
            else
                hud_q_reg <= HPW'(hud_full >> HUD_K);
        end
    end

    logic [HPW-1:0] hud_eff;
    assign hud_eff = hud_voxelized_reg ? '0 : hud_q_reg;

    // raster position
    logic [XW-1:0] x_reg;
    logic [9:0]    y_reg;
    logic [XW-1:0] col_reg;
    logic [TW-1:0] xin_reg;
    logic [9:0]    row_reg;
    logic [TW-1:0] yin_reg;
    logic          x_last;
    logic          y_last;
    logic          xin_last;
    logic          yin_last;
    logic          active;

    assign x_last   = (x_reg == XW'(w_eff - 1'b1));
    assign y_last   = (y_reg == 10'(h_eff - 11'd1));
    assign xin_last = (xin_reg == TW'(s_eff - 1'b1));
    assign yin_last = (yin_reg == TW'(s_eff - 1'b1));
    assign active   = (HPW'(y_reg) >= hud_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            col_reg <= '0;
            xin_reg <= '0;
            row_reg <= '0;
            yin_reg <= '0;
        end
        else if (restart)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            col_reg <= '0;
            xin_reg <= '0;
            row_reg <= '0;
            yin_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (x_last)
            begin
                x_reg   <= '0;
                col_reg <= '0;
                xin_reg <= '0;
                if (y_last)
                begin
                    y_reg   <= '0;
                    row_reg <= '0;
                    yin_reg <= '0;
                end
                else
                begin
                    y_reg <= y_reg + 1'b1;
                    if (active)
                    begin
                        if (yin_last)
                        begin
                            yin_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end
                        else
                        begin
                            yin_reg <= yin_reg + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
                if (xin_last)
                begin
                    xin_reg <= '0;
                    col_reg <= col_reg + 1'b1;
                end
                else
                begin
                    xin_reg <= xin_reg + 1'b1;
                end
            end
        end
    end

    // pixel and tile flags captured at the transfer
    logic [23:0]   pix_reg;
    logic [XW-1:0] pend_col_reg;
    logic [9:0]    pend_row_reg;
    logic          pend_active_reg;
    logic          pend_end_reg;
    logic          pend_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg         <= pix_data;
            pend_col_reg    <= col_reg;
            pend_row_reg    <= row_reg;
            pend_active_reg <= active;
            pend_end_reg    <= (xin_last || x_last) && (yin_last || y_last);
            pend_last_reg   <= x_last && y_last;
        end
    end

    // column sum memory: {count, blue, green, red}
    logic [MEMW-1:0] sum_mem [MAX_COLUMNS];
    logic [MEMW-1:0] rd_reg;
    logic [SUMW-1:0] new_r;
    logic [SUMW-1:0] new_g;
    logic [SUMW-1:0] new_b;
    logic [CNTW-1:0] new_cnt;
    logic            close;

    assign new_r   = rd_reg[SUMW-1:0] + SUMW'(pix_reg[7:0]);
    assign new_g   = rd_reg[2*SUMW-1:SUMW] + SUMW'(pix_reg[15:8]);
    assign new_b   = rd_reg[3*SUMW-1:2*SUMW] + SUMW'(pix_reg[23:16]);
    assign new_cnt = rd_reg[MEMW-1:3*SUMW] + 1'b1;
    assign close   = pend_active_reg && pend_end_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            sum_mem[clr_addr_reg] <= '0;
        else if (cmd.update && pend_active_reg)
            sum_mem[pend_col_reg] <= close ? '0 : {new_cnt, new_b, new_g, new_r};
        if (cmd.accept)
            rd_reg <= sum_mem[col_reg];
    end

    // three restoring dividers sharing the count as divisor
    logic [4:0]      div_cnt_reg;
    logic [SUMW-1:0] dq_r_reg;
    logic [SUMW-1:0] dq_g_reg;
    logic [SUMW-1:0] dq_b_reg;
    logic [CNTW-1:0] dr_r_reg;
    logic [CNTW-1:0] dr_g_reg;
    logic [CNTW-1:0] dr_b_reg;
    logic [CNTW-1:0] dvs_reg;
    logic            div_done;

    assign div_done = (div_cnt_reg == 5'(SUMW));

    function automatic logic [CNTW+SUMW-1:0] div_step(input logic [SUMW-1:0] q,
                                                      input logic [CNTW-1:0] r,
                                                      input logic [CNTW-1:0] d);
        logic [CNTW:0] t;
        t = {r, q[SUMW-1]};
        if (t >= {1'b0, d})
            div_step = {CNTW'(t - {1'b0, d}), q[SUMW-2:0], 1'b1};
        else
            div_step = {CNTW'(t), q[SUMW-2:0], 1'b0};
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            div_cnt_reg <= '0;
            dq_r_reg    <= new_r;
            dq_g_reg    <= new_g;
            dq_b_reg    <= new_b;
            dr_r_reg    <= '0;
            dr_g_reg    <= '0;
            dr_b_reg    <= '0;
            dvs_reg     <= (new_cnt == '0) ? CNTW'(1) : new_cnt;
        end
        else if (cmd.div_step && !div_done)
        begin
            div_cnt_reg          <= div_cnt_reg + 1'b1;
            {dr_r_reg, dq_r_reg} <= div_step(dq_r_reg, dr_r_reg, dvs_reg);
            {dr_g_reg, dq_g_reg} <= div_step(dq_g_reg, dr_g_reg, dvs_reg);
            {dr_b_reg, dq_b_reg} <= div_step(dq_b_reg, dr_b_reg, dvs_reg);
        end
    end

    // averages and luminance
    logic [7:0]  ar;
    logic [7:0]  ag;
    logic [7:0]  ab;
    logic [7:0]  avg_r_reg;
    logic [7:0]  avg_g_reg;
    logic [7:0]  avg_b_reg;
    logic [17:0] luma_reg;

    assign ar = (dq_r_reg > SUMW'(255)) ? 8'd255 : dq_r_reg[7:0];
    assign ag = (dq_g_reg > SUMW'(255)) ? 8'd255 : dq_g_reg[7:0];
    assign ab = (dq_b_reg > SUMW'(255)) ? 8'd255 : dq_b_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (cmd.luma)
        begin
            avg_r_reg <= ar;
            avg_g_reg <= ag;
            avg_b_reg <= ab;
            luma_reg  <= 18'd299 * 18'(ar) + 18'd587 * 18'(ag) + 18'd114 * 18'(ab);
        end
    end

    // height: gain product, split reciprocal multiply, then sum and shift
    logic [4:0]  hgt_cnt_reg;
    logic [27:0] lg_reg;
    logic [45:0] hp_lo_reg;
    logic [45:0] hp_hi_reg;
    logic [63:0] hgt_full;
    logic [15:0] hq_reg;
    logic        hgt_done;

    assign hgt_full = {hp_hi_reg, 18'd0} + 64'(hp_lo_reg);
    assign hgt_done = (hgt_cnt_reg == 5'd3);

    always_ff @(posedge clk)
    begin
        if (cmd.luma)
        begin
            hgt_cnt_reg <= '0;
        end
        else if (cmd.hgt_step && !hgt_done)
        begin
            hgt_cnt_reg <= hgt_cnt_reg + 1'b1;
            case (hgt_cnt_reg)
                5'd0:
                begin
                    lg_reg <= 28'(luma_reg) * 28'(height_gain_reg);
                end
                5'd1:
                begin
                    hp_lo_reg <= 46'(lg_reg) * 46'(HGT_M_LO);
                    hp_hi_reg <= 46'(lg_reg) * 46'(HGT_M_HI);
                end
                default:
                begin
                    hq_reg <= hgt_full[HGT_SH+15:HGT_SH];
                end
            endcase
        end
    end

    // output register
    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic        out_user_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {2'b00, 16'(hq_reg + 16'(talc_pkg::HEIGHT_BASE)), luma_reg,
                             avg_b_reg, avg_g_reg, avg_r_reg, pend_row_reg,
                             10'(pend_col_reg)};
            out_user_reg <= (luma_reg >= 18'(talc_pkg::VISIBLE_MIN));
            out_last_reg <= pend_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

    assign sts.restart    = restart;
    assign sts.clear_done = clr_last && hud_done;
    assign sts.close      = close;
    assign sts.div_done   = div_done;
    assign sts.hgt_done   = hgt_done;
    assign sts.out_busy   = out_valid_reg && !out_ready;

endmodule
`default_nettype wire

// ===== hdl/tile_average_luma_cull_core.sv =====
// Tile average, luminance and cull block: top level.
//
// Pixels stream in on s_axis in raster order, one transfer per pixel, and are
// summed per tile column in a MAX_COLUMNS-deep memory. When a pixel closes a
// tile, one result leaves on m_axis with the tile position, averages, luma,
// column height (tuser = visible, tlast = last tile of the frame).
// A pixel that closes no tile is read from the memory, then written back.
// A closing pixel holds the input through the transfer, the write back,
// 18 steps of the serial average dividers and their done state, the luma state,
// the height states (gain product, reciprocal multiply, sum and shift, done),
// and the load of the output register; the result is valid in the cycle after the load.
// The output register holds a finished result while the next pixels are
// accepted; a stalled receiver only blocks the next tile close.
// Reset and every write to a defined register start a clearing pass over the
// MAX_COLUMNS memory words during which s_axis_tready is low; the frame position
// restarts at the first pixel.
// cfg writes are always ready and are expected only while the block is idle.
`default_nettype none
module tile_average_luma_cull_core #(
    parameter int MAX_TILE       = talc_pkg::MAX_TILE_DEF,
    parameter int MAX_COLUMNS    = talc_pkg::MAX_COLUMNS_DEF,
    parameter int HUD_BASE_LINES = talc_pkg::HUD_BASE_LINES_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [talc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [talc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // red, green, blue
    input  wire [talc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // tile_col, tile_row, avg_red, avg_green, avg_blue, luma_milli, column_height, pad
    output logic [talc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // visible
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    talc_pkg::cmd_t cmd;
    talc_pkg::sts_t sts;
    logic           out_user;

    assign cfg_ready = 1'b1;

    talc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    talc_dp #(
        .MAX_TILE       (MAX_TILE),
        .MAX_COLUMNS    (MAX_COLUMNS),
        .HUD_BASE_LINES (HUD_BASE_LINES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_data  (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (out_user),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = out_user;

`ifndef ASSERT_OFF
    a_one_pixel_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second pixel accepted before the first was stored");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result loaded over a stalled result");

    a_visible_matches_luma: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[61:44] >= 18'd6375)))
        else $error("visible flag disagrees with luma");
`endif

endmodule
`default_nettype wire
